### rtl/lsgc_pkg.sv
// Shared types and constants for the levels stretch and gamma curve block.
`timescale 1ns / 1ps

package lsgc_pkg;

  localparam int SAMPLE_W = 8;                 // channel sample and table word width
  localparam int TABLE_DEPTH = 256;            // gamma table entries
  localparam int CFG_INDEX_W = 2;              // register index width
  localparam int CFG_DATA_W = 8;               // widest register

  // Divider: numerator 510*d + n, divisor 2*n, quotient below 256.
  localparam int QUOT_W = 8;
  localparam int NUM_W = 17;
  localparam int DEN_W = 9;

  localparam logic [SAMPLE_W-1:0] FULL_SCALE = 8'd255;
  localparam logic [SAMPLE_W-1:0] LOW_LIMIT = 8'd253;

  localparam logic [CFG_INDEX_W-1:0] REG_LOW_CUT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_CUT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAMMA_ENABLE = 2'd2;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TABLE = 1'b1;

  // How the stretched value of a sample is formed.
  typedef enum logic [1:0] {
    CLS_PASS = 2'd0,   // stretch inactive, sample passes through
    CLS_ZERO = 2'd1,   // maps to black
    CLS_FULL = 2'd2,   // maps to white
    CLS_DIV  = 2'd3    // rounded quotient from the divider
  } cls_t;

  // Request data that travels beside the divider.
  typedef struct packed {
    logic                kind;
    cls_t                cls;
    logic [SAMPLE_W-1:0] value;   // pass-through sample, or table index for a write
    logic [SAMPLE_W-1:0] word;    // table word for a write
  } side_t;

endpackage

### rtl/lsgc_if.sv
// Request and result channel interfaces with valid/ready handshake.
`timescale 1ns / 1ps

interface lsgc_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] sample;
  logic [7:0] table_index;
  logic [7:0] table_word;

  modport source (output valid, kind, sample, table_index, table_word, input ready);
  modport sink (input valid, kind, sample, table_index, table_word, output ready);
endinterface

interface lsgc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] mapped;

  modport source (output valid, mapped, input ready);
  modport sink (input valid, mapped, output ready);
endinterface

### rtl/levels_stretch_gamma_curve_core.sv
// Top level of the levels stretch and gamma curve block.
`timescale 1ns / 1ps

// Levels adjustment for 8-bit channel samples.
// Requests arrive on ch_in (valid/ready). A request of kind sample is
// stretched between the black and white points and, when gamma is enabled,
// looked up in the 256-entry gamma table; its result leaves on ch_out.
// A request of kind table write stores one gamma table entry and yields
// no result. Configuration (low_cut, high_cut, gamma_enable) is written
// through cfg_we/cfg_index/cfg_data, which the user must do only while no
// request is in flight; the block does not enforce this. One request per
// cycle is taken while the output buffer has a free entry: the stretch
// divides in a pipelined divider with one quotient bit per stage, and the
// gamma table is one RAM read or written by at most one request per cycle,
// in request order. A request passes one classification stage, one operand
// stage, eight divider stages and the registered table read. A two-entry
// output buffer holds results, so requests are accepted while one waits;
// ch_in.ready falls only when both are full; then the whole pipeline holds.
// Reset clears the registers to their reset values and empties the
// pipeline and buffer; the gamma table content is undefined until written.
module levels_stretch_gamma_curve_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [lsgc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lsgc_pkg::CFG_DATA_W-1:0]  cfg_data,
  lsgc_in_if.sink                          ch_in,
  lsgc_out_if.source                       ch_out
);

  localparam int SW = lsgc_pkg::SAMPLE_W;

  // Configuration registers.
  logic [SW-1:0] low_cut;
  logic [SW-1:0] high_cut;
  logic          gamma_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_cut      <= '0;
      high_cut     <= lsgc_pkg::FULL_SCALE;
      gamma_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lsgc_pkg::REG_LOW_CUT:      low_cut <= cfg_data[SW-1:0];
        lsgc_pkg::REG_HIGH_CUT:     high_cut <= cfg_data[SW-1:0];
        lsgc_pkg::REG_GAMMA_ENABLE: gamma_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The pipeline advances whenever the output buffer has a free entry.
  logic [1:0] buf_count;
  logic       en;

  assign en = (buf_count != 2'd2);
  assign ch_in.ready = en;

  // Classification of the incoming sample against the black and white points.
  logic           active;
  logic           empty_window;
  lsgc_pkg::cls_t cls;
  lsgc_pkg::side_t in_side;

  assign active = ((low_cut != '0) || (high_cut != lsgc_pkg::FULL_SCALE)) &&
                  (low_cut < lsgc_pkg::LOW_LIMIT) && (high_cut != '0);
  assign empty_window = ({1'b0, high_cut} <= ({1'b0, low_cut} + 9'd1));

  always_comb begin
    priority if (!active) begin
      cls = lsgc_pkg::CLS_PASS;
    end else if (empty_window) begin
      cls = lsgc_pkg::CLS_ZERO;
    end else if (ch_in.sample <= low_cut) begin
      cls = lsgc_pkg::CLS_ZERO;
    end else if (ch_in.sample >= (high_cut - 8'd1)) begin
      cls = lsgc_pkg::CLS_FULL;
    end else begin
      cls = lsgc_pkg::CLS_DIV;
    end
  end

  always_comb begin
    in_side.kind  = ch_in.kind;
    in_side.cls   = cls;
    in_side.value = (ch_in.kind == lsgc_pkg::KIND_TABLE) ? ch_in.table_index : ch_in.sample;
    in_side.word  = ch_in.table_word;
  end

  // Classification stage.
  logic            c_valid;
  lsgc_pkg::side_t c_side;
  logic [SW-1:0]   c_d;
  logic [SW-1:0]   c_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= ch_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_side <= in_side;
      c_d    <= ch_in.sample - low_cut;
      c_n    <= high_cut - low_cut - 8'd1;
    end
  end

  // Divider pipeline.
  logic                          div_valid;
  logic [lsgc_pkg::QUOT_W-1:0]   div_quot;
  lsgc_pkg::side_t               div_side;

  lsgc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c_valid),
    .in_side   (c_side),
    .d         (c_d),
    .n         (c_n),
    .out_valid (div_valid),
    .out_quot  (div_quot),
    .out_side  (div_side)
  );

  // Stretched value, then one gamma table access per request.
  logic [SW-1:0] stretched;

  always_comb begin
    unique case (div_side.cls)
      lsgc_pkg::CLS_PASS: stretched = div_side.value;
      lsgc_pkg::CLS_ZERO: stretched = '0;
      lsgc_pkg::CLS_FULL: stretched = lsgc_pkg::FULL_SCALE;
      lsgc_pkg::CLS_DIV:  stretched = div_quot;
      default:            stretched = '0;
    endcase
  end

  // A table write lands at the same stage where samples read, so a later
  // sample always sees every earlier write without forwarding.
  logic          table_we;
  logic [SW-1:0] table_q;

  assign table_we = en && div_valid && (div_side.kind == lsgc_pkg::KIND_TABLE);

  lsgc_ram #(
    .WIDTH (lsgc_pkg::SAMPLE_W),
    .DEPTH (lsgc_pkg::TABLE_DEPTH)
  ) u_gamma_table (
    .clk   (clk),
    .we    (table_we),
    .waddr (div_side.value),
    .wdata (div_side.word),
    .re    (en),
    .raddr (stretched),
    .rdata (table_q)
  );

  // Lookup stage, aligned with the RAM read data.
  logic          r_valid;
  logic          r_sample;
  logic          r_gamma;
  logic [SW-1:0] r_value;
  logic [SW-1:0] result;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (en) begin
      r_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_sample <= (div_side.kind == lsgc_pkg::KIND_SAMPLE);
      r_gamma  <= gamma_enable;
      r_value  <= stretched;
    end
  end

  assign result = r_gamma ? table_q : r_value;

  // Two-entry output buffer: buf0 is the head shown on ch_out.
  logic          push;
  logic          pop;
  logic [SW-1:0] buf0;
  logic [SW-1:0] buf1;

  assign push = en && r_valid && r_sample;
  assign pop  = ch_out.valid && ch_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_count <= '0;
    end else begin
      buf_count <= buf_count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && (buf_count == 2'd1)) begin
        buf0 <= result;
      end else begin
        buf0 <= buf1;
        if (push) begin
          buf1 <= result;
        end
      end
    end else if (push) begin
      if (buf_count == 2'd0) begin
        buf0 <= result;
      end else begin
        buf1 <= result;
      end
    end
  end

  assign ch_out.valid  = (buf_count != 2'd0);
  assign ch_out.mapped = buf0;

endmodule

### rtl/lsgc_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module lsgc_ram #(
  parameter int WIDTH = lsgc_pkg::SAMPLE_W,
  parameter int DEPTH = lsgc_pkg::TABLE_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/lsgc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband data.
`timescale 1ns / 1ps

module lsgc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  lsgc_pkg::side_t               in_side,
  input  logic [lsgc_pkg::SAMPLE_W-1:0] d,
  input  logic [lsgc_pkg::SAMPLE_W-1:0] n,
  output logic                          out_valid,
  output logic [lsgc_pkg::QUOT_W-1:0]   out_quot,
  output lsgc_pkg::side_t               out_side
);

  localparam int QW = lsgc_pkg::QUOT_W;
  localparam int NW = lsgc_pkg::NUM_W;
  localparam int DW = lsgc_pkg::DEN_W;

  // Index 0 is the operand preparation stage; index s+1 holds s+1 quotient bits.
  logic                  s_valid [QW+1];
  logic [NW-1:0]         s_rem   [QW+1];
  logic [DW-1:0]         s_den   [QW+1];
  logic [QW-1:0]         s_quot  [QW+1];
  lsgc_pkg::side_t       s_side  [QW+1];

  // Rounded quotient: (2*255*d + n) / (2*n).
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid[0] <= 1'b0;
    end else if (en) begin
      s_valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_rem[0]  <= {d, 9'b0} - {8'b0, d, 1'b0} + {9'b0, n};
      s_den[0]  <= {n, 1'b0};
      s_quot[0] <= '0;
      s_side[0] <= in_side;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int SH = QW - 1 - s;
    logic [NW-1:0] trial;
    logic          fits;

    assign trial = {{(NW-DW){1'b0}}, s_den[s]} << SH;
    assign fits = (s_rem[s] >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        s_valid[s+1] <= 1'b0;
      end else if (en) begin
        s_valid[s+1] <= s_valid[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_rem[s+1]  <= fits ? (s_rem[s] - trial) : s_rem[s];
        s_den[s+1]  <= s_den[s];
        s_quot[s+1] <= {s_quot[s][QW-2:0], fits};
        s_side[s+1] <= s_side[s];
      end
    end
  end

  assign out_valid = s_valid[QW];
  assign out_quot  = s_quot[QW];
  assign out_side  = s_side[QW];

endmodule

### rtl/lsgc_checker.sv
// Port-level assertions for the levels stretch and gamma curve block, with bind.
`timescale 1ns / 1ps

module lsgc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] mapped
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mapped))
    else $error("result changed while stalled");

  // Reset empties the output buffer.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // With no result waiting the block always takes requests.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("request refused with empty output buffer");

  // A full buffer stays full until the receiver takes a result.
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    !in_ready && !out_ready |=> !in_ready && out_valid)
    else $error("buffer drained without a result being taken");

endmodule

bind levels_stretch_gamma_curve_core lsgc_checker u_lsgc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (ch_in.ready),
  .out_valid (ch_out.valid),
  .out_ready (ch_out.ready),
  .mapped    (ch_out.mapped)
);
